// ===== sv/rcwcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Raycast wall column setup package
// Register map and configuration constants used by the wall column setup unit.
// ----------------------------------------------------------------------------
`default_nettype none
package rcwcs_pkg;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int PITCH_W = 9;
	localparam logic [PITCH_W-1:0] PITCH_RESET = 9'd100;
	localparam logic [ADDR_W-1:0] REG_PITCH_OFFSET = 3'd0;
	localparam int ROW_W = 11;
	localparam int TCOL_W = 6;
	localparam logic [1:0] FACE_Y_NEG = 2'd0;
	localparam logic [1:0] FACE_X_POS = 2'd1;
	localparam logic [1:0] FACE_Y_POS = 2'd2;
	localparam logic [1:0] FACE_X_NEG = 2'd3;
endpackage
`default_nettype wire

// ===== sv/rcwcs_div_cell.sv =====
// ----------------------------------------------------------------------------
// Raycast wall column setup divider cell
// One restoring division step per cell; hands its partial result onward.
// ----------------------------------------------------------------------------
`default_nettype none
module rcwcs_div_cell #(
	parameter int DW = 32,
	parameter int QW = 16,
	parameter int SW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [DW-1:0] rem_in,
	input  wire logic [DW-1:0] den_in,
	input  wire logic [QW-1:0] quot_in,
	input  wire logic          num_bit,
	input  wire logic [SW-1:0] sb_in,
	output logic               out_valid,
	output logic      [DW-1:0] rem_out,
	output logic      [DW-1:0] den_out,
	output logic      [QW-1:0] quot_out,
	output logic      [SW-1:0] sb_out
);
	logic [DW:0] trial;
	logic        ge;
	logic        valid_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] quot_q;
	logic [SW-1:0] sb_q;

	assign trial = {rem_in, num_bit};
	assign ge = trial >= {1'b0, den_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
			quot_q <= {quot_in[QW-2:0], ge};
			den_q <= den_in;
			sb_q <= sb_in;
		end
	end

	assign out_valid = valid_q;
	assign rem_out = rem_q;
	assign den_out = den_q;
	assign quot_out = quot_q;
	assign sb_out = sb_q;
endmodule
`default_nettype wire

// ===== sv/raycast_wall_column_setup_unit.sv =====
// ----------------------------------------------------------------------------
// Raycast wall column setup unit
// Turns one ray's grid walk result into the draw data of one screen column.
// ----------------------------------------------------------------------------
// The unit accepts one transaction per clock and returns one result per
// transaction, in order. The pipeline holds two rows of divider cells, one
// quotient bit per cell: sixteen for the line height and one per numerator bit
// for the texture step. When the output is stalled the whole pipeline holds.
`default_nettype none
module raycast_wall_column_setup_unit #(
	parameter int SCREEN_HEIGHT = 480,
	parameter int TEX_WIDTH = 64,
	parameter int TEX_HEIGHT = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [rcwcs_pkg::ADDR_W-1:0] paddr,
	input  wire logic [rcwcs_pkg::DATA_W-1:0] pwdata,
	output logic      [rcwcs_pkg::DATA_W-1:0] prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         hit_side,
	input  wire logic [31:0]                  x_side_distance,
	input  wire logic [31:0]                  y_side_distance,
	input  wire logic [31:0]                  x_step_distance,
	input  wire logic [31:0]                  y_step_distance,
	input  wire logic signed [15:0]           x_direction,
	input  wire logic signed [15:0]           y_direction,
	input  wire logic [23:0]                  player_x,
	input  wire logic [23:0]                  player_y,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [31:0]                       perp_distance,
	output logic [1:0]                        wall_face,
	output logic [15:0]                       column_height,
	output logic [rcwcs_pkg::ROW_W-1:0]       first_row,
	output logic [rcwcs_pkg::ROW_W-1:0]       last_row,
	output logic [rcwcs_pkg::TCOL_W-1:0]      texture_column,
	output logic [31:0]                       texture_step,
	output logic [31:0]                       texture_start
);
	import rcwcs_pkg::*;

	localparam int TWW = $clog2(TEX_WIDTH + 1);
	localparam int NW = $clog2(TEX_HEIGHT + 1) + 16;
	localparam int N1 = 16;
	localparam int SB1 = 1 + 2 + TCOL_W;
	localparam int SB2 = 32 + 2 + TCOL_W + ROW_W + ROW_W + 15;
	localparam int PW = 15 + NW;
	localparam logic [NW-1:0] NUM2 = NW'(TEX_HEIGHT) << 16;
	localparam logic [ROW_W-1:0] HALF_SH = ROW_W'(SCREEN_HEIGHT / 2);
	localparam logic [ROW_W-1:0] LAST_SH = ROW_W'(SCREEN_HEIGHT - 1);

	logic en;
	logic [PITCH_W-1:0] pitch_q;

	assign pready = 1'b1;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= PITCH_RESET;
		end else if (psel && penable && pwrite && paddr == REG_PITCH_OFFSET) begin
			pitch_q <= pwdata[PITCH_W-1:0];
		end
	end

	assign prdata = (paddr == REG_PITCH_OFFSET) ? DATA_W'(pitch_q) : '0;

	// Stage 1: distance, face, operand selection.
	logic v_s1, v_s2, v_s3;
	logic [31:0] dist_s1, dist_s2, dist_s3;
	logic [1:0] face_s1, face_s2, face_s3;
	logic mirror_s1, mirror_s2, mirror_s3;
	logic sat_s1, sat_s2, sat_s3;
	logic signed [15:0] dir_s1;
	logic [23:0] pos_s1, pos_s2;
	logic signed [48:0] prod_s2;
	logic [30+TWW-1:0] cprod_s3;
	logic [31:0] dist_c;
	logic [29:0] frac_c;
	logic [TWW-1:0] colraw_c, col_c;

	always_comb begin
		if (!hit_side) begin
			dist_c = (x_side_distance >= x_step_distance) ?
				x_side_distance - x_step_distance : '0;
		end else begin
			dist_c = (y_side_distance >= y_step_distance) ?
				y_side_distance - y_step_distance : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s1 <= dist_c;
			sat_s1 <= dist_c <= 32'(SCREEN_HEIGHT);
			if (!hit_side) begin
				face_s1 <= (x_direction > 0) ? FACE_X_POS : FACE_X_NEG;
				mirror_s1 <= x_direction > 0;
				dir_s1 <= y_direction;
				pos_s1 <= player_y;
			end else begin
				face_s1 <= (y_direction > 0) ? FACE_Y_POS : FACE_Y_NEG;
				mirror_s1 <= y_direction < 0;
				dir_s1 <= x_direction;
				pos_s1 <= player_x;
			end
			dist_s2 <= dist_s1;
			face_s2 <= face_s1;
			mirror_s2 <= mirror_s1;
			sat_s2 <= sat_s1;
			pos_s2 <= pos_s1;
			prod_s2 <= $signed({1'b0, dist_s1}) * dir_s1;
			dist_s3 <= dist_s2;
			face_s3 <= face_s2;
			mirror_s3 <= mirror_s2;
			sat_s3 <= sat_s2;
			cprod_s3 <= (30+TWW)'(frac_c) * (30+TWW)'(TEX_WIDTH);
		end
	end

	assign frac_c = 30'({pos_s2, 14'b0}) + prod_s2[29:0];
	assign colraw_c = cprod_s3[30+TWW-1:30];
	assign col_c = mirror_s3 ? TWW'(TEX_WIDTH - 1) - colraw_c : colraw_c;

	// Line height divider row.
	logic [N1:0] v1;
	logic [31:0] rem1 [0:N1];
	logic [31:0] den1 [0:N1];
	logic [15:0] quot1 [0:N1];
	logic [SB1-1:0] sb1 [0:N1];

	assign v1[0] = v_s3;
	assign rem1[0] = 32'(SCREEN_HEIGHT);
	assign den1[0] = dist_s3;
	assign quot1[0] = '0;
	assign sb1[0] = {sat_s3, face_s3, TCOL_W'(col_c)};

	for (genvar k = 0; k < N1; k++) begin : g_div1
		rcwcs_div_cell #(.DW(32), .QW(16), .SW(SB1)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(v1[k]), .rem_in(rem1[k]), .den_in(den1[k]),
			.quot_in(quot1[k]), .num_bit(1'b0), .sb_in(sb1[k]),
			.out_valid(v1[k+1]), .rem_out(rem1[k+1]), .den_out(den1[k+1]),
			.quot_out(quot1[k+1]), .sb_out(sb1[k+1])
		);
	end

	// Row bounds.
	logic [15:0] height_c;
	logic [14:0] half_c;
	logic [ROW_W-1:0] centre_c;
	logic v_m;
	logic [31:0] dist_m;
	logic [1:0] face_m;
	logic [TCOL_W-1:0] col_m;
	logic [15:0] height_m;
	logic [ROW_W-1:0] top_m, bottom_m;
	logic [14:0] term_m;

	assign height_c = sb1[N1][SB1-1] ? 16'hFFFF : quot1[N1];
	assign half_c = height_c[15:1];
	assign centre_c = HALF_SH + ROW_W'(pitch_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m <= 1'b0;
		end else if (en) begin
			v_m <= v1[N1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_m <= den1[N1];
			face_m <= sb1[N1][SB1-2 -: 2];
			col_m <= sb1[N1][TCOL_W-1:0];
			height_m <= height_c;
			top_m <= (15'(centre_c) > half_c) ? ROW_W'(15'(centre_c) - half_c) : '0;
			term_m <= (half_c > 15'(centre_c)) ? half_c - 15'(centre_c) : '0;
			bottom_m <= (16'(centre_c) + 16'(half_c) >= 16'(SCREEN_HEIGHT)) ? LAST_SH
				: ROW_W'(16'(centre_c) + 16'(half_c));
		end
	end

	// Texture step divider row.
	logic [NW:0] v2;
	logic [15:0] rem2 [0:NW];
	logic [15:0] den2 [0:NW];
	logic [NW-1:0] quot2 [0:NW];
	logic [SB2-1:0] sb2 [0:NW];

	assign v2[0] = v_m;
	assign rem2[0] = '0;
	assign den2[0] = height_m;
	assign quot2[0] = '0;
	assign sb2[0] = {dist_m, face_m, col_m, top_m, bottom_m, term_m};

	for (genvar k = 0; k < NW; k++) begin : g_div2
		rcwcs_div_cell #(.DW(16), .QW(NW), .SW(SB2)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(v2[k]), .rem_in(rem2[k]), .den_in(den2[k]),
			.quot_in(quot2[k]), .num_bit(NUM2[NW-1-k]), .sb_in(sb2[k]),
			.out_valid(v2[k+1]), .rem_out(rem2[k+1]), .den_out(den2[k+1]),
			.quot_out(quot2[k+1]), .sb_out(sb2[k+1])
		);
	end

	// Start product and output register.
	logic v_p;
	logic [PW-1:0] prod_p;
	logic [31:0] step_p;
	logic [SB2-1:0] sb_p;
	logic [15:0] height_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_p <= v2[NW];
			out_valid <= v_p;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_p <= PW'(sb2[NW][14:0]) * PW'(quot2[NW]);
			step_p <= (den2[NW] == '0) ? 32'hFFFF_FFFF : 32'(quot2[NW]);
			sb_p <= sb2[NW];
			height_p <= den2[NW];
			perp_distance <= sb_p[SB2-1 -: 32];
			wall_face <= sb_p[SB2-33 -: 2];
			texture_column <= sb_p[SB2-35 -: TCOL_W];
			first_row <= sb_p[15+2*ROW_W-1 -: ROW_W];
			last_row <= sb_p[15+ROW_W-1 -: ROW_W];
			column_height <= height_p;
			texture_step <= step_p;
			texture_start <= (|prod_p[PW-1:32]) ? 32'hFFFF_FFFF : prod_p[31:0];
		end
	end
endmodule
`default_nettype wire

// ===== sv/rcwcs_checker.sv =====
// ----------------------------------------------------------------------------
// Raycast wall column setup checker
// Port-level checks of the column setup unit, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none
module rcwcs_checker #(
	parameter int SCREEN_HEIGHT = 480
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] perp_distance,
	input wire logic [15:0] column_height,
	input wire logic [10:0] last_row
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(perp_distance))
		else $error("result changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output stall");

	a_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && perp_distance == 32'd0 |-> column_height == 16'hFFFF)
		else $error("zero distance without saturated height");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> last_row <= 11'(SCREEN_HEIGHT - 1))
		else $error("last row beyond screen");
endmodule

bind raycast_wall_column_setup_unit rcwcs_checker #(.SCREEN_HEIGHT(SCREEN_HEIGHT)) u_rcwcs_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .perp_distance(perp_distance),
	.column_height(column_height), .last_row(last_row)
);
`default_nettype wire
